// ===== rtl/gmps_pkg.sv =====
// shared constants, types and helpers for the grid path sum and count block
package gmps_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int CELL_BITS   = 16;

   localparam int COL_BITS     = $clog2(MAX_COLUMNS);
   localparam int ROW_BITS     = $clog2(MAX_ROWS);
   localparam int REG_BITS     = 11;
   localparam int INDEX_BITS   = 2;
   localparam int SUM_BITS     = 28;
   localparam int OUT_SUM_BITS = 27;
   localparam int COUNT_BITS   = 63;

   typedef enum logic [INDEX_BITS-1:0] {
      REG_ROW_COUNT    = 2'd0,
      REG_COLUMN_COUNT = 2'd1
   } reg_index_type;

   typedef logic signed [SUM_BITS-1:0] sum_type;
   typedef logic [COUNT_BITS-1:0]      count_type;

   typedef struct packed {
      count_type count;
      sum_type   sum;
   } line_type;

   // cell waiting for its line buffer read
   typedef struct packed {
      logic                        valid;
      logic signed [CELL_BITS-1:0] cell_value;
      logic                        has_up;
      logic                        has_left;
      logic                        last_grid;
      logic                        bypass;
      logic [COL_BITS-1:0]         addr;
   } stage_type;

   function automatic logic [ROW_BITS-1:0] rows_m1(input logic [REG_BITS-1:0] v);
      logic [ROW_BITS-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (v > REG_BITS'(MAX_ROWS)) begin
         r = ROW_BITS'(MAX_ROWS - 1);
      end else begin
         r = ROW_BITS'(v - REG_BITS'(1));
      end
      return r;
   endfunction

   function automatic logic [COL_BITS-1:0] cols_m1(input logic [REG_BITS-1:0] v);
      logic [COL_BITS-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (v > REG_BITS'(MAX_COLUMNS)) begin
         r = COL_BITS'(MAX_COLUMNS - 1);
      end else begin
         r = COL_BITS'(v - REG_BITS'(1));
      end
      return r;
   endfunction

endpackage

// ===== rtl/gmps_ram.sv =====
// generic single-port-write, registered-read memory
module gmps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/gmps_seq.sv =====
// grid position counters, dimension registers and read-issue stage
module gmps_seq import gmps_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic signed [CELL_BITS-1:0] req_cell_value,
   input  logic                        hold,
   input  logic                        csr_valid,
   input  logic [INDEX_BITS-1:0]       csr_index,
   input  logic [REG_BITS-1:0]         csr_data,
   output logic                        csr_ready,
   output logic                        rd_en,
   output logic [COL_BITS-1:0]         rd_addr,
   output stage_type                   stage
);

   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] rows_m1_ff, rows_m1_in;
   logic [COL_BITS-1:0] cols_m1_ff, cols_m1_in;
   stage_type           stage_ff, stage_in;
   logic                accept;
   logic                csr_write;
   logic                restart;
   logic                last_col;
   logic                last_row;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign accept    = req_valid & ~hold;
   assign last_col  = (col_ff == cols_m1_ff);
   assign last_row  = (row_ff == rows_m1_ff);
   assign rd_en     = accept;
   assign rd_addr   = col_ff;
   assign stage     = stage_ff;

   always_comb begin
      rows_m1_in = rows_m1_ff;
      cols_m1_in = cols_m1_ff;
      restart    = 1'b0;
      if (csr_write) begin
         case (csr_index)
            REG_ROW_COUNT: begin
               rows_m1_in = rows_m1(csr_data);
               restart    = 1'b1;
            end
            REG_COLUMN_COUNT: begin
               cols_m1_in = cols_m1(csr_data);
               restart    = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in.valid      = 1'b1;
         stage_in.cell_value = req_cell_value;
         stage_in.has_up     = (row_ff != '0);
         stage_in.has_left   = (col_ff != '0);
         stage_in.last_grid  = last_col & last_row;
         stage_in.addr       = col_ff;
         // entry being written this cycle by the cell ahead
         stage_in.bypass     = stage_ff.valid & (stage_ff.addr == col_ff);
      end else if (!hold) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff         <= '0;
         col_ff         <= '0;
         rows_m1_ff     <= '0;
         cols_m1_ff     <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         rows_m1_ff <= rows_m1_in;
         cols_m1_ff <= cols_m1_in;
         stage_ff   <= stage_in;
      end
   end

   a_bypass_single_column: assert property (@(posedge clock) disable iff (reset)
      stage_ff.valid && stage_ff.bypass |-> cols_m1_ff == '0)
      else $error("line buffer bypass with more than one column");

   a_last_grid_at_origin: assert property (@(posedge clock) disable iff (reset)
      accept && last_col && last_row && !restart |=> row_ff == '0 && col_ff == '0)
      else $error("position not back at the first cell after the final cell");

endmodule

// ===== rtl/gmps_cell.sv =====
// per-cell sum and count update, line buffer write-back and result register
module gmps_cell import gmps_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  stage_type                      stage,
   input  logic                           advance,
   input  line_type                       rd_data,
   input  logic                           rsp_stall,
   output logic                           wr_en,
   output line_type                       wr_data,
   output logic [COL_BITS-1:0]            wr_addr,
   output logic                           rsp_valid,
   output logic [COUNT_BITS-1:0]          rsp_path_count,
   output logic signed [OUT_SUM_BITS-1:0] rsp_best_sum
);

   sum_type                        prev_sum_ff;
   count_type                      prev_count_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]          rsp_count_ff;
   logic signed [OUT_SUM_BITS-1:0] rsp_sum_ff, best_sat;
   sum_type                        up_sum, base_sum, cell_ext, new_sum;
   count_type                      up_count, new_count;
   logic [COUNT_BITS:0]            count_add;

   assign up_sum   = stage.bypass ? prev_sum_ff : rd_data.sum;
   assign up_count = stage.bypass ? prev_count_ff : rd_data.count;
   assign cell_ext = SUM_BITS'(stage.cell_value);
   assign count_add = {1'b0, up_count} + {1'b0, prev_count_ff};

   always_comb begin
      if (stage.has_up && stage.has_left) begin
         base_sum  = (up_sum > prev_sum_ff) ? up_sum : prev_sum_ff;
         new_count = count_add[COUNT_BITS] ? '1 : count_add[COUNT_BITS-1:0];
      end else if (stage.has_up) begin
         base_sum  = up_sum;
         new_count = up_count;
      end else if (stage.has_left) begin
         base_sum  = prev_sum_ff;
         new_count = prev_count_ff;
      end else begin
         base_sum  = '0;
         new_count = COUNT_BITS'(1);
      end
   end

   assign new_sum = cell_ext + base_sum;

   always_comb begin
      if (new_sum[SUM_BITS-1] != new_sum[SUM_BITS-2]) begin
         best_sat = new_sum[SUM_BITS-1] ? {1'b1, {(OUT_SUM_BITS-1){1'b0}}}
                                        : {1'b0, {(OUT_SUM_BITS-1){1'b1}}};
      end else begin
         best_sat = new_sum[OUT_SUM_BITS-1:0];
      end
   end

   assign wr_en         = advance;
   assign wr_addr       = stage.addr;
   assign wr_data.sum   = new_sum;
   assign wr_data.count = new_count;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (advance && stage.last_grid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prev_sum_ff   <= new_sum;
         prev_count_ff <= new_count;
         if (stage.last_grid) begin
            rsp_count_ff <= new_count;
            rsp_sum_ff   <= best_sat;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_count_ff;
   assign rsp_best_sum   = rsp_sum_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !(advance && stage.last_grid))
      else $error("result overwritten while still waiting");

   a_origin_count_one: assert property (@(posedge clock) disable iff (reset)
      advance && !stage.has_up && !stage.has_left |-> new_count == COUNT_BITS'(1))
      else $error("first cell count is not one");

endmodule

// ===== rtl/grid_max_path_sum_and_count.sv =====
// top level of the grid maximum path sum and monotone path count block
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_cell_value
//   rsp      out        rsp_valid/rsp_stall  rsp_path_count, rsp_best_sum
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// one cell per cycle while req_stall is low; a cell reads the row above from
// the line buffer ram at acceptance and is updated and written back as it
// advances; the result is registered as the final cell of a grid advances
// the line buffer needs no clearing after reset, every entry is written first
// a stalled result only holds intake once the next grid's final cell is due

module grid_max_path_sum_and_count import gmps_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [CELL_BITS-1:0]    req_cell_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [COUNT_BITS-1:0]          rsp_path_count,
   output logic signed [OUT_SUM_BITS-1:0] rsp_best_sum,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [INDEX_BITS-1:0]          csr_index,
   input  logic [REG_BITS-1:0]            csr_data
);

   stage_type           stage;
   logic                hold;
   logic                advance;
   logic                rd_en;
   logic [COL_BITS-1:0] rd_addr;
   logic                wr_en;
   logic [COL_BITS-1:0] wr_addr;
   line_type            wr_data;
   line_type            rd_data;

   assign hold      = stage.valid & stage.last_grid & rsp_valid & rsp_stall;
   assign advance   = stage.valid & ~hold;
   assign req_stall = hold;

   gmps_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_cell_value (req_cell_value),
      .hold           (hold),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .csr_ready      (csr_ready),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .stage          (stage)
   );

   gmps_ram #(
      .WIDTH ($bits(line_type)),
      .DEPTH (MAX_COLUMNS)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gmps_cell u_cell (
      .clock          (clock),
      .reset          (reset),
      .stage          (stage),
      .advance        (advance),
      .rd_data        (rd_data),
      .rsp_stall      (rsp_stall),
      .wr_en          (wr_en),
      .wr_data        (wr_data),
      .wr_addr        (wr_addr),
      .rsp_valid      (rsp_valid),
      .rsp_path_count (rsp_path_count),
      .rsp_best_sum   (rsp_best_sum)
   );

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && stage.valid)
      else $error("intake held without a waiting result");

endmodule

// ===== bench/tb_grid_max_path_sum_and_count.sv =====
// testbench for the grid maximum path sum and path count block
module tb_grid_max_path_sum_and_count;
   import gmps_pkg::*;

   localparam int SETTLE_CYCLES = 6;
   localparam int STALL_LIMIT   = 4000;
   localparam int LONG_HOLD     = 300;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_ITEMS  = 620;

   localparam logic [INDEX_BITS-1:0] REG_UNUSED = 2'd3;
   localparam logic signed [CELL_BITS-1:0] CELL_HIGH = {1'b0, {(CELL_BITS-1){1'b1}}};
   localparam logic signed [CELL_BITS-1:0] CELL_LOW  = {1'b1, {(CELL_BITS-1){1'b0}}};
   localparam int SUM_HIGH = 2 ** (OUT_SUM_BITS - 1) - 1;
   localparam int SUM_LOW  = -(2 ** (OUT_SUM_BITS - 1));

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      count_type                      count;
      logic signed [OUT_SUM_BITS-1:0] sum;
   } grid_total_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [CELL_BITS-1:0]    req_cell_value = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [COUNT_BITS-1:0]          rsp_path_count;
   logic signed [OUT_SUM_BITS-1:0] rsp_best_sum;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [INDEX_BITS-1:0]          csr_index = '0;
   logic [REG_BITS-1:0]            csr_data = '0;

   grid_max_path_sum_and_count dut (.*);

   // stimulus and expectations
   logic signed [CELL_BITS-1:0] pending_cells[$];
   grid_total_type              expected_totals[$];
   int                          cells_outstanding = 0;
   int                          mismatches = 0;
   int                          send_idle_pct = 0;
   int                          recv_stall_pct = 0;
   bit                          long_hold_go = 1'b0;
   int                          hold_left = 0;
   int                          quiet_cycles = 0;

   // predictor state
   int                  above_sum[MAX_COLUMNS];
   count_type           above_count[MAX_COLUMNS];
   int                  prev_sum = 0;
   count_type           prev_count = '0;
   int unsigned         cur_row = 0;
   int unsigned         cur_col = 0;
   logic [REG_BITS-1:0] rows_reg = 1;
   logic [REG_BITS-1:0] cols_reg = 1;

   always #5 clock = ~clock;

   function automatic int unsigned effective_dim(input logic [REG_BITS-1:0] v,
                                                 input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic count_type count_add(input count_type a, input count_type b);
      logic [COUNT_BITS:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[COUNT_BITS] ? '1 : total[COUNT_BITS-1:0];
   endfunction

   function automatic void restart_grid();
      prev_sum = 0;
      prev_count = '0;
      cur_row = 0;
      cur_col = 0;
   endfunction

   function automatic void apply_reg_write(input logic [INDEX_BITS-1:0] idx,
                                           input logic [REG_BITS-1:0] val);
      if (idx == REG_ROW_COUNT) begin
         rows_reg = val;
         restart_grid();
      end else if (idx == REG_COLUMN_COUNT) begin
         cols_reg = val;
         restart_grid();
      end
   endfunction

   function automatic void track_cell(input logic signed [CELL_BITS-1:0] value_in);
      int unsigned    n_rows;
      int unsigned    n_cols;
      int             value;
      int             up;
      int             best;
      count_type      paths;
      grid_total_type total;
      n_rows = effective_dim(rows_reg, MAX_ROWS);
      n_cols = effective_dim(cols_reg, MAX_COLUMNS);
      value = value_in;
      if (cur_row == 0 && cur_col == 0) begin
         best = value;
         paths = COUNT_BITS'(1);
      end else if (cur_row != 0 && cur_col != 0) begin
         up = above_sum[cur_col];
         best = value + ((up > prev_sum) ? up : prev_sum);
         paths = count_add(above_count[cur_col], prev_count);
      end else if (cur_row != 0) begin
         best = value + above_sum[cur_col];
         paths = above_count[cur_col];
      end else begin
         best = value + prev_sum;
         paths = prev_count;
      end
      above_sum[cur_col] = best;
      above_count[cur_col] = paths;
      prev_sum = best;
      prev_count = paths;
      if (cur_col + 1 < n_cols) begin
         cur_col++;
         return;
      end
      cur_col = 0;
      prev_sum = 0;
      prev_count = '0;
      if (cur_row + 1 < n_rows) begin
         cur_row++;
         return;
      end
      cur_row = 0;
      if (best > SUM_HIGH) best = SUM_HIGH;
      if (best < SUM_LOW) best = SUM_LOW;
      total.count = paths;
      total.sum = OUT_SUM_BITS'(best);
      expected_totals.push_back(total);
   endfunction

   function automatic logic signed [CELL_BITS-1:0] random_cell_value();
      case ($urandom_range(7))
         0: return CELL_HIGH;
         1: return CELL_LOW;
         default: return CELL_BITS'($urandom);
      endcase
   endfunction

   task automatic offer_cell(input logic signed [CELL_BITS-1:0] v);
      pending_cells.push_back(v);
      cells_outstanding++;
   endtask

   task automatic wait_idle();
      while (cells_outstanding != 0 || expected_totals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_BITS-1:0] idx,
                            input logic [REG_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_reg_write(idx, val);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 56 : (mode == IDLE_BOTH) ? 23 : 0;
      recv_stall_pct = (mode == IDLE_RECEIVER) ? 56 : (mode == IDLE_BOTH) ? 23 : 0;
   endtask

   // cell driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            track_cell(req_cell_value);
            cells_outstanding--;
         end
         if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_cell_value <= pending_cells.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      grid_total_type total;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_totals.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result: path_count %0d, best_sum %0d",
                           rsp_path_count, rsp_best_sum);
            end else begin
               total = expected_totals.pop_front();
               if (rsp_path_count !== total.count) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("path_count mismatch: expected %0d, got %0d",
                              total.count, rsp_path_count);
               end
               if (rsp_best_sum !== total.sum) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("best_sum mismatch: expected %0d, got %0d",
                              total.sum, rsp_best_sum);
               end
            end
         end
         if (long_hold_go) begin
            hold_left = LONG_HOLD;
            long_hold_go = 1'b0;
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
         if (hold_left != 0) hold_left--;
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_grid_max_path_sum_and_count: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int r;
      int c;
      int n;
      int seg;
      int grids;
      int random_items;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single cell grids at reset size
      set_idling(IDLE_NONE);
      offer_cell(CELL_HIGH);
      offer_cell(CELL_LOW);
      offer_cell('0);
      offer_cell(CELL_BITS'(-1));
      offer_cell(CELL_BITS'(1));
      wait_idle();

      write_reg(REG_ROW_COUNT, REG_BITS'(2));
      write_reg(REG_COLUMN_COUNT, REG_BITS'(3));
      offer_cell(CELL_HIGH);
      offer_cell(CELL_HIGH);
      offer_cell(CELL_HIGH);
      offer_cell(CELL_LOW);
      offer_cell(CELL_BITS'(-1));
      offer_cell(CELL_BITS'(1));
      wait_idle();

      // register write abandons a partial grid
      write_reg(REG_COLUMN_COUNT, REG_BITS'(2));
      offer_cell(CELL_LOW);
      offer_cell(CELL_HIGH);
      offer_cell(CELL_BITS'(5));
      wait_idle();
      write_reg(REG_ROW_COUNT, REG_BITS'(2));
      offer_cell(CELL_BITS'(7));
      offer_cell(CELL_LOW);
      offer_cell(CELL_HIGH);
      offer_cell(CELL_BITS'(-3));
      wait_idle();

      // unknown index leaves the grid position alone
      offer_cell(CELL_HIGH);
      offer_cell(CELL_BITS'(-2));
      wait_idle();
      write_reg(REG_UNUSED, REG_BITS'(5));
      offer_cell(CELL_LOW);
      offer_cell(CELL_HIGH);
      wait_idle();

      // zero sizes act as one
      write_reg(REG_ROW_COUNT, '0);
      write_reg(REG_COLUMN_COUNT, REG_BITS'(3));
      for (n = 0; n < 3; n++) offer_cell(random_cell_value());
      wait_idle();
      set_idling(IDLE_BOTH);
      write_reg(REG_ROW_COUNT, REG_BITS'(2));
      write_reg(REG_COLUMN_COUNT, '0);
      for (n = 0; n < 2; n++) offer_cell(CELL_HIGH);
      wait_idle();

      r = 2;
      c = 1;
      seg = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         set_idling(idle_mode_type'(seg % 4));
         if (seg == 4) begin
            r = 1;
            c = 1;
            write_reg(REG_ROW_COUNT, '0);
            write_reg(REG_COLUMN_COUNT, REG_BITS'(1));
            long_hold_go = 1'b1;
            for (n = 0; n < 40; n++) offer_cell(random_cell_value());
            random_items += 40;
         end else begin
            case ($urandom_range(3))
               0: begin
                  r = ($urandom_range(7) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
                  write_reg(REG_ROW_COUNT, REG_BITS'(r));
               end
               1: begin
                  c = ($urandom_range(7) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
                  write_reg(REG_COLUMN_COUNT, REG_BITS'(c));
               end
               default: begin
                  r = ($urandom_range(7) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
                  c = ($urandom_range(7) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
                  write_reg(REG_COLUMN_COUNT, REG_BITS'(c));
                  write_reg(REG_ROW_COUNT,
                            REG_BITS'((r == 1 && $urandom_range(1)) ? 0 : r));
               end
            endcase
            grids = $urandom_range(1, 4);
            for (n = 0; n < grids * r * c; n++) offer_cell(random_cell_value());
            random_items += grids * r * c;
            // broken grid left for the next register write to discard
            if (r * c > 1 && $urandom_range(4) == 0) begin
               grids = $urandom_range(1, r * c - 1);
               for (n = 0; n < grids; n++) offer_cell(random_cell_value());
               random_items += grids;
            end
         end
         wait_idle();
         seg++;
      end

      wait_idle();
      if (mismatches == 0 && expected_totals.size() == 0)
         $display("tb_grid_max_path_sum_and_count: clean");
      else
         $display("tb_grid_max_path_sum_and_count: errors");
      $finish;
   end

endmodule
